// ===== hdl/hco_pkg.sv =====
// Shared types, constants and the exp(-x) table for the history confidence oracle.
`default_nettype none

package hco_pkg;

   // Field widths.
   localparam int VAL_W   = 17;   // unsigned Q16 value, 0..65536
   localparam int IN_W    = 18;   // signed Q16 input field
   localparam int STEPS_W = 9;
   localparam int COUNT_W = 9;
   localparam int FRAC_W  = 16;

   localparam int CAPACITY_DEFAULT = 256;

   localparam logic [VAL_W-1:0] ONE_Q16            = 17'd65536;
   localparam logic [VAL_W-1:0] DEFAULT_CONFIDENCE = 17'd60293;

   // Item codes.
   localparam logic FUNC_RECORD = 1'b0;
   localparam logic FUNC_QUERY  = 1'b1;

   // exp(-k/256) table, k = 0..256.
   localparam int EXP_SIZE  = 257;
   localparam int EXP_LAST  = 256;
   localparam int EXP_IDX_W = $clog2(EXP_SIZE);

   typedef logic [EXP_SIZE-1:0][VAL_W-1:0] exp_table_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } hco_state_type;

   // Divide a series term by the term number; each arm divides by a literal.
   function automatic logic [63:0] div_term(input logic [63:0] v, input int unsigned n);
      unique case (n)
         1:       return v;
         2:       return v / 2;
         3:       return v / 3;
         4:       return v / 4;
         5:       return v / 5;
         6:       return v / 6;
         7:       return v / 7;
         8:       return v / 8;
         9:       return v / 9;
         10:      return v / 10;
         11:      return v / 11;
         12:      return v / 12;
         13:      return v / 13;
         14:      return v / 14;
         15:      return v / 15;
         16:      return v / 16;
         17:      return v / 17;
         18:      return v / 18;
         19:      return v / 19;
         20:      return v / 20;
         21:      return v / 21;
         22:      return v / 22;
         23:      return v / 23;
         24:      return v / 24;
         default: return v;
      endcase
   endfunction

   // Q30 Taylor series, 24 truncated terms, rounded to Q16.
   function automatic exp_table_type build_exp_table();
      exp_table_type t;
      logic [63:0]   x;
      logic [63:0]   term;
      logic [63:0]   pos;
      logic [63:0]   neg;
      for (int k = 0; k < EXP_SIZE; k++) begin
         x    = 64'(k) << 22;
         term = 64'd1 << 30;
         pos  = term;
         neg  = 64'd0;
         for (int n = 1; n <= 24; n++) begin
            term = div_term((term * x) >> 30, n);
            if (n[0]) begin
               neg = neg + term;
            end else begin
               pos = pos + term;
            end
         end
         t[k] = VAL_W'(((pos - neg) + (64'd1 << 13)) >> 14);
      end
      return t;
   endfunction

   localparam exp_table_type EXP_TABLE = build_exp_table();

   // Clamp a signed Q16 value to 0..1.0.
   function automatic logic [VAL_W-1:0] clamp_unit(input logic signed [IN_W-1:0] v);
      if (v < 0) begin
         return '0;
      end else if (v > $signed({1'b0, ONE_Q16})) begin
         return ONE_Q16;
      end else begin
         return v[VAL_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

// ===== hdl/hco_channels.sv =====
// Valid/ready channel interfaces for request and response transactions.
`default_nettype none

interface hco_req_if;
   import hco_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     func;
   logic signed [IN_W-1:0]   acceptance;
   logic signed [IN_W-1:0]   entropy;
   logic        [STEPS_W-1:0] steps;
   logic signed [IN_W-1:0]   confidence;

   modport source (output valid, output func, output acceptance, output entropy,
                   output steps, output confidence, input ready);
   modport sink   (input valid, input func, input acceptance, input entropy,
                   input steps, input confidence, output ready);
endinterface

interface hco_rsp_if;
   import hco_pkg::*;

   logic               valid;
   logic               ready;
   logic               safe;
   logic [COUNT_W-1:0] stored_count;

   modport source (output valid, output safe, output stored_count, input ready);
   modport sink   (input valid, input safe, input stored_count, output ready);
endinterface

`default_nettype wire

// ===== hdl/history_confidence_oracle_core.sv =====
// Top level: event ring memory with a pipelined confidence walk for queries.
`default_nettype none

// Channel    Dir  Handshake      Payload
// req_chan   in   valid/ready    func, acceptance, entropy, steps, confidence
// rsp_chan   out  valid/ready    safe, stored_count
// csr        in   csr_we only    csr_wdata (default_confidence, 17 bits)
//
// Record transaction: the accept moves IDLE to FINISH, which loads the result register.
// Query transaction: the single read port of the event memory walks one entry per cycle
// into a five-stage exp/multiply/accumulate pipeline.
// A failing query (zero steps, too few events) skips the walk and goes straight to FINISH.
// Reset clears pointer, fill count, control and the default confidence only; the event
// memory has no clearing pass; the fill count keeps a query off unwritten entries.
// A result waits in the response register while rsp_chan.ready is low; the next
// transaction is still accepted and parks in FINISH until the register frees up.

module history_confidence_oracle_core #(
   parameter int CAPACITY = hco_pkg::CAPACITY_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   hco_req_if.sink                   req_chan,
   hco_rsp_if.source                 rsp_chan,
   input  logic                      csr_we,
   input  logic [hco_pkg::VAL_W-1:0] csr_wdata
);
   import hco_pkg::*;

   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int FILL_W = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (FILL_W > STEPS_W) ? FILL_W : STEPS_W;
   localparam int PROD_W = VAL_W + 8 + 1;
   localparam int TERM_W = 2 * VAL_W;
   localparam int THR_W  = VAL_W + STEPS_W;
   localparam int SUM_W  = TERM_W + STEPS_W;
   localparam int MEM_W  = 2 * VAL_W;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CAPACITY - 1);
   localparam logic [FILL_W-1:0] FULL      = FILL_W'(CAPACITY);

   // Event memory: {acceptance, entropy}, one entry per event.
   logic [MEM_W-1:0] event_mem [CAPACITY];

   hco_state_type state_ff, state_in;

   logic [ADDR_W-1:0]  wp_ff;
   logic [FILL_W-1:0]  fill_ff;
   logic [VAL_W-1:0]   default_conf_ff;
   logic [4:0]         pipe_v_ff;
   logic               rsp_valid_ff;
   logic               rsp_safe_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   // Query context.
   logic               is_query_ff;
   logic               fail_ff;
   logic [STEPS_W-1:0] steps_ff;
   logic [VAL_W-1:0]   conf_ff;
   logic [STEPS_W-1:0] issue_left_ff;
   logic [STEPS_W-1:0] terms_left_ff;
   logic [ADDR_W-1:0]  rd_addr_ff;
   logic [THR_W-1:0]   thr_ff;
   logic [SUM_W-1:0]   sum_ff;

   // Walk pipeline.
   logic [MEM_W-1:0]   rd_data_ff;
   logic [VAL_W-1:0]   ei1_ff, di1_ff, a1_ff;
   logic [7:0]         f1_ff;
   logic [PROD_W-1:0]  prod2_ff;
   logic [VAL_W-1:0]   ei2_ff, a2_ff;
   logic [VAL_W-1:0]   e3_ff, a3_ff;
   logic [TERM_W-1:0]  term4_ff;

   logic               accept;
   logic               rec_wr;
   logic               rd_en;
   logic               load_rsp;
   logic               q_fail;
   logic [VAL_W-1:0]   q_conf;
   logic signed [IN_W-1:0] conf_sel;
   logic [ADDR_W-1:0]  newest_addr;
   logic [MEM_W-1:0]   wr_data;
   logic [CMP_W-1:0]   fill_ext;
   logic               finish_safe;
   logic [VAL_W-1:0]   ent_rd;
   logic [EXP_IDX_W-1:0] tbl_idx;
   logic [VAL_W-1:0]   ei_lk, di_lk;
   logic [PROD_W-1:0]  rnd;

   assign accept   = req_chan.valid && req_chan.ready;
   assign rec_wr   = accept && (req_chan.func == FUNC_RECORD);
   assign rd_en    = (state_ff == ST_WALK) && (issue_left_ff != '0);
   assign req_chan.ready = (state_ff == ST_IDLE);

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.safe         = rsp_safe_ff;
   assign rsp_chan.stored_count = rsp_count_ff;

   assign fill_ext    = CMP_W'(fill_ff);
   assign newest_addr = (wp_ff == '0) ? LAST_ADDR : wp_ff - 1'b1;
   assign wr_data     = {clamp_unit(req_chan.acceptance), clamp_unit(req_chan.entropy)};

   // Pick the required confidence: zero or less falls back to the register.
   always_comb begin
      if (req_chan.confidence <= 0) begin
         conf_sel = $signed({1'b0, default_conf_ff});
      end else begin
         conf_sel = req_chan.confidence;
      end
      q_conf = clamp_unit(conf_sel);
      q_fail = (req_chan.steps == '0) || (CMP_W'(req_chan.steps) > fill_ext);
   end

   // Mean test without division: sum >= conf * steps * 2^16.
   assign finish_safe = is_query_ff && !fail_ff && (sum_ff >= (SUM_W'(thr_ff) << FRAC_W));

   // Next state and strobes.
   always_comb begin
      state_in = state_ff;
      load_rsp = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_chan.func == FUNC_RECORD || q_fail) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            // Last term lands in the accumulator this edge.
            if (pipe_v_ff[4] && terms_left_ff == STEPS_W'(1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Hold until the response register is free, then load it.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         wp_ff           <= '0;
         fill_ff         <= '0;
         default_conf_ff <= DEFAULT_CONFIDENCE;
         pipe_v_ff       <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pipe_v_ff <= {pipe_v_ff[3:0], rd_en};
         if (csr_we) begin
            default_conf_ff <= csr_wdata;
         end
         if (rec_wr) begin
            // Advance the ring pointer; saturate the fill count at capacity.
            wp_ff <= (wp_ff == LAST_ADDR) ? '0 : wp_ff + 1'b1;
            if (fill_ff != FULL) begin
               fill_ff <= fill_ff + 1'b1;
            end
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Event memory: one write port for records, one registered read port for the walk.
   always_ff @(posedge clock) begin
      if (rec_wr) begin
         event_mem[wp_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= event_mem[rd_addr_ff];
      end
   end

   // exp(-h) table lookup on the entry just read.
   always_comb begin
      ent_rd  = rd_data_ff[VAL_W-1:0];
      tbl_idx = ent_rd[VAL_W-1:8];
      if (tbl_idx >= EXP_IDX_W'(EXP_LAST)) begin
         ei_lk = EXP_TABLE[EXP_LAST];
         di_lk = '0;
      end else begin
         ei_lk = EXP_TABLE[tbl_idx];
         di_lk = EXP_TABLE[tbl_idx] - EXP_TABLE[tbl_idx + 1'b1];
      end
   end

   assign rnd = prod2_ff + PROD_W'(128);

   // Query context and walk pipeline.
   always_ff @(posedge clock) begin
      if (accept) begin
         is_query_ff   <= (req_chan.func == FUNC_QUERY);
         fail_ff       <= q_fail;
         steps_ff      <= req_chan.steps;
         conf_ff       <= q_conf;
         issue_left_ff <= req_chan.steps;
         terms_left_ff <= req_chan.steps;
         rd_addr_ff    <= newest_addr;
         sum_ff        <= '0;
      end
      if (rd_en) begin
         // Step back toward older events, wrapping around the ring.
         rd_addr_ff    <= (rd_addr_ff == '0) ? LAST_ADDR : rd_addr_ff - 1'b1;
         issue_left_ff <= issue_left_ff - 1'b1;
      end
      thr_ff <= THR_W'(conf_ff) * THR_W'(steps_ff);

      // Stage 1: table values.
      ei1_ff <= ei_lk;
      di1_ff <= di_lk;
      f1_ff  <= ent_rd[7:0];
      a1_ff  <= rd_data_ff[MEM_W-1:VAL_W];
      // Stage 2: interpolation product.
      prod2_ff <= PROD_W'(di1_ff) * PROD_W'(f1_ff);
      ei2_ff   <= ei1_ff;
      a2_ff    <= a1_ff;
      // Stage 3: rounded interpolation.
      e3_ff <= ei2_ff - VAL_W'(rnd >> 8);
      a3_ff <= a2_ff;
      // Stage 4: acceptance * exp(-entropy), exact Q32.
      term4_ff <= TERM_W'(a3_ff) * TERM_W'(e3_ff);

      if (pipe_v_ff[4]) begin
         sum_ff        <= sum_ff + SUM_W'(term4_ff);
         terms_left_ff <= terms_left_ff - 1'b1;
      end

      if (load_rsp) begin
         rsp_safe_ff  <= finish_safe;
         rsp_count_ff <= fill_ext[COUNT_W-1:0];
      end
   end

   // Fill count never passes capacity.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL)
      else $error("fill count above capacity");

   // Walk pipeline is drained whenever a new transaction can be taken.
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> pipe_v_ff == '0)
      else $error("walk pipeline busy in idle");

   // Fill count moves only on an accepted record.
   a_fill_on_record: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && fill_ff != $past(fill_ff)) |->
         $past(req_chan.valid && req_chan.ready && req_chan.func == FUNC_RECORD))
      else $error("fill count changed without a record");

   // A response is raised only out of FINISH.
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response loaded outside finish");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking bench for the history confidence oracle: directed and random record/query traffic.
`timescale 1ns / 100ps

module tb;
   import hco_pkg::*;

   // Bench constants.
   localparam int DEPTH       = CAPACITY_DEFAULT;
   localparam int RESET_LEN   = 12;
   localparam int IDLE_PCT    = 28;
   // Longest quiet stretch of a correct run is one full-depth walk plus a few
   // stalls; allow many times that before declaring a hang.
   localparam int STALL_LIMIT = 4000;
   // Let a full walk pass after the last result.
   localparam int TAIL_CYCLES = DEPTH + 40;
   localparam int RANDOM_ITEMS = 1750;

   typedef longint unsigned u64_type;

   typedef struct {
      logic                     func;
      logic signed [IN_W-1:0]   acceptance;
      logic signed [IN_W-1:0]   entropy;
      logic        [STEPS_W-1:0] steps;
      logic signed [IN_W-1:0]   confidence;
   } req_item_type;

   typedef struct {
      logic               safe;
      logic [COUNT_W-1:0] stored_count;
   } verdict_type;

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [VAL_W-1:0] csr_wdata;

   hco_req_if req_chan ();
   hco_rsp_if rsp_chan ();

   history_confidence_oracle_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Shadow of the event history and the default register.
   logic [VAL_W-1:0] hist_accept  [DEPTH];
   logic [VAL_W-1:0] hist_entropy [DEPTH];
   int unsigned      hist_wr_ptr;
   int unsigned      hist_fill;
   logic [VAL_W-1:0] model_default;
   u64_type          exp_lut [EXP_SIZE];

   verdict_type pending_verdicts [$];
   int unsigned mismatches;
   int unsigned stall_cycles;
   bit          steady;   // suppress idling on both sides

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Build the exp(-k/256) lookup from a truncated Q30 Taylor series.
   function automatic void build_exp_lut();
      u64_type x;
      u64_type term;
      u64_type pos;
      u64_type neg;
      for (int k = 0; k < EXP_SIZE; k++) begin
         x    = u64_type'(k) << 22;
         term = u64_type'(1) << 30;
         pos  = term;
         neg  = 0;
         for (int n = 1; n <= 24; n++) begin
            term = ((term * x) >> 30) / u64_type'(n);
            if (n % 2 == 1) begin
               neg += term;
            end else begin
               pos += term;
            end
         end
         exp_lut[k] = (pos - neg + (u64_type'(1) << 13)) >> 14;
      end
   endfunction

   // Interpolate exp(-h) between table points; h is Q16 in 0..1.0.
   function automatic u64_type exp_of_neg(input logic [VAL_W-1:0] h);
      int unsigned i;
      int unsigned f;
      u64_type     d;
      i = h >> 8;
      f = h & 8'hFF;
      if (i >= EXP_LAST) return exp_lut[EXP_LAST];
      d = exp_lut[i] - exp_lut[i + 1];
      return exp_lut[i] - ((d * f + 128) >> 8);
   endfunction

   function automatic logic [VAL_W-1:0] unit_clamp(input logic signed [IN_W-1:0] v);
      if (v < 0) return '0;
      if (v > int'(ONE_Q16)) return ONE_Q16;
      return VAL_W'(v);
   endfunction

   // Advance the shadow history by one transaction and return its verdict.
   function automatic verdict_type predict_verdict(input req_item_type it);
      verdict_type      v;
      logic [VAL_W-1:0] conf;
      u64_type          sum;
      int unsigned      slot;
      v.safe = 1'b0;
      if (it.func == FUNC_RECORD) begin
         hist_accept[hist_wr_ptr]  = unit_clamp(it.acceptance);
         hist_entropy[hist_wr_ptr] = unit_clamp(it.entropy);
         hist_wr_ptr = (hist_wr_ptr + 1) % DEPTH;
         if (hist_fill < DEPTH) hist_fill++;
      end else begin
         // Zero or negative confidence falls back to the register.
         if (it.confidence <= 0) begin
            conf = unit_clamp($signed({1'b0, model_default}));
         end else begin
            conf = unit_clamp(it.confidence);
         end
         if (it.steps != 0 && it.steps <= DEPTH && it.steps <= hist_fill) begin
            sum = 0;
            for (int unsigned i = 0; i < it.steps; i++) begin
               slot = (hist_wr_ptr + DEPTH - 1 - i) % DEPTH;
               sum += u64_type'(hist_accept[slot]) * exp_of_neg(hist_entropy[slot]);
            end
            v.safe = (sum >= ((u64_type'(conf) * it.steps) << FRAC_W));
         end
      end
      v.stored_count = COUNT_W'(hist_fill);
      return v;
   endfunction

   // Record transaction; steps and confidence carry random junk.
   function automatic req_item_type record_item(input logic signed [IN_W-1:0] acc,
                                                input logic signed [IN_W-1:0] ent);
      req_item_type it;
      it.func       = FUNC_RECORD;
      it.acceptance = acc;
      it.entropy    = ent;
      it.steps      = STEPS_W'($urandom);
      it.confidence = IN_W'($urandom);
      return it;
   endfunction

   // Query transaction; acceptance and entropy carry random junk.
   function automatic req_item_type query_item(input logic [STEPS_W-1:0] steps,
                                               input logic signed [IN_W-1:0] conf);
      req_item_type it;
      it.func       = FUNC_QUERY;
      it.acceptance = IN_W'($urandom);
      it.entropy    = IN_W'($urandom);
      it.steps      = steps;
      it.confidence = conf;
      return it;
   endfunction

   // Present one transaction, hold it until accepted, then log its verdict.
   // Valid stays high on return, so a back-to-back item need not raise it again.
   task automatic send_item(input req_item_type it);
      if (!steady) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_chan.valid      <= 1'b1;
      req_chan.func       <= it.func;
      req_chan.acceptance <= it.acceptance;
      req_chan.entropy    <= it.entropy;
      req_chan.steps      <= it.steps;
      req_chan.confidence <= it.confidence;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pending_verdicts.push_back(predict_verdict(it));
   endtask

   // Drop valid and hold off until every outstanding verdict has returned.
   task automatic drain_verdicts();
      req_chan.valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
   endtask

   // Write the default confidence register with the block idle.
   task automatic write_default(input logic [VAL_W-1:0] value);
      drain_verdicts();
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we        <= 1'b0;
      model_default = value;
   endtask

   // Queries against an empty history must all fail.
   task automatic test_empty_store();
      send_item(query_item(0, 1));
      send_item(query_item(1, 0));
      send_item(query_item(STEPS_W'(DEPTH), IN_W'(ONE_Q16)));
   endtask

   // Out-of-range event values clamp to 0 and 1.0.
   task automatic test_record_clamping();
      send_item(record_item(-131072, -131072));
      send_item(record_item(-1, 131071));
      send_item(record_item(0, 65536));
      send_item(record_item(65536, 65537));
      send_item(record_item(65537, 0));
      send_item(record_item(32768, 32768));
      send_item(record_item(131071, 1));
   endtask

   // Step count bounds and confidence extremes, seven events held.
   task automatic test_query_limits();
      send_item(query_item(0, 1));
      send_item(query_item(STEPS_W'(hist_fill), 1));
      send_item(query_item(STEPS_W'(hist_fill + 1), 1));
      send_item(query_item(1, 1));
      send_item(query_item(1, 65536));
      send_item(query_item(1, 65537));
      send_item(query_item(1, 131071));
      send_item(query_item(2, -131072));
      send_item(query_item(3, 0));
      send_item(query_item(STEPS_W'(DEPTH), 1));
      send_item(query_item(STEPS_W'(DEPTH + 1), 1));
      send_item(query_item(511, 1));
   endtask

   // Fallback confidence across register extremes, including above 1.0.
   task automatic test_default_register();
      write_default(0);
      send_item(query_item(1, 0));
      send_item(query_item(STEPS_W'(hist_fill), -5));
      write_default(ONE_Q16);
      send_item(query_item(1, -1));
      write_default(17'h1FFFF);
      send_item(query_item(3, 0));
      write_default(1);
      send_item(query_item(2, -131072));
      write_default(VAL_W'($urandom_range(65536)));
      send_item(query_item(4, 0));
      write_default(DEFAULT_CONFIDENCE);
      send_item(query_item(5, 0));
   endtask

   // Mostly well-formed records and queries with random content, some noise.
   task automatic test_random_traffic(input int unsigned count);
      req_item_type           it;
      int unsigned            acc_floor;
      int unsigned            ent_ceiling;
      int unsigned            r;
      int unsigned            top;
      int unsigned            cfg_turn;
      logic signed [IN_W-1:0] c;
      logic [STEPS_W-1:0]     s;
      cfg_turn = 0;
      acc_floor = 58000;
      ent_ceiling = 4000;
      for (int unsigned n = 0; n < count; n++) begin
         // Switch between a healthy and a noisy event history now and then.
         if (n % 250 == 0) begin
            if ($urandom_range(1) == 1) begin
               acc_floor   = 58000;
               ent_ceiling = 4000;
            end else begin
               acc_floor   = 16000;
               ent_ceiling = 65536;
            end
         end
         steady = (n >= 600 && n < 900);
         // Retune the fallback between phases; the write drains first.
         if (n % 400 == 399) begin
            case (cfg_turn % 4)
               0:       write_default(0);
               1:       write_default(ONE_Q16);
               2:       write_default(17'h1FFFF);
               default: write_default(VAL_W'($urandom_range(65536, 40000)));
            endcase
            cfg_turn++;
         end
         if (n == 1000) drain_verdicts();
         r = $urandom_range(99);
         if (r < 70) begin
            it = record_item(IN_W'($urandom_range(65536, acc_floor)),
                             IN_W'($urandom_range(ent_ceiling, 0)));
         end else if (r < 78) begin
            it = record_item(IN_W'($urandom), IN_W'($urandom));
         end else if (r < 94) begin
            // Favor short walks; only a few span the whole history.
            if (hist_fill == 0) begin
               s = 1;
            end else begin
               r   = $urandom_range(99);
               top = (hist_fill < 32) ? hist_fill : 32;
               if (r < 70) begin
                  s = STEPS_W'($urandom_range(top, 1));
               end else if (r < 92) begin
                  s = STEPS_W'($urandom_range(hist_fill, 1));
               end else begin
                  s = STEPS_W'(hist_fill);
               end
            end
            r = $urandom_range(99);
            if (r < 80) begin
               c = IN_W'($urandom_range(65536, 40000));
            end else if (r < 92) begin
               c = IN_W'($urandom_range(131072, 0));
               c = -c;
            end else begin
               c = IN_W'($urandom_range(131071, 65537));
            end
            it = query_item(s, c);
         end else begin
            it = query_item(STEPS_W'($urandom), IN_W'($urandom));
         end
         send_item(it);
      end
      steady = 1'b0;
   endtask

   // Check each accepted result against the oldest prediction and drive
   // the response-side ready; also track quiet cycles for the watchdog.
   initial begin
      verdict_type want;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            stall_cycles = 0;
         end else begin
            if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
               stall_cycles = 0;
            end else begin
               stall_cycles++;
            end
            if (rsp_chan.valid && rsp_chan.ready) begin
               if (pending_verdicts.size() == 0) begin
                  mismatches++;
                  $display("%0t: unexpected result, expected none, actual safe=%0d count=%0d",
                           $time, rsp_chan.safe, rsp_chan.stored_count);
               end else begin
                  want = pending_verdicts.pop_front();
                  if (rsp_chan.safe !== want.safe) begin
                     mismatches++;
                     $display("%0t: safe mismatch, expected %0d actual %0d",
                              $time, want.safe, rsp_chan.safe);
                  end
                  if (rsp_chan.stored_count !== want.stored_count) begin
                     mismatches++;
                     $display("%0t: stored_count mismatch, expected %0d actual %0d",
                              $time, want.stored_count, rsp_chan.stored_count);
                  end
               end
            end
         end
         rsp_chan.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Watchdog: end the run if nothing moves for too long.
   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      build_exp_lut();
      hist_wr_ptr   = 0;
      hist_fill     = 0;
      model_default = DEFAULT_CONFIDENCE;
      mismatches    = 0;
      stall_cycles  = 0;
      steady        = 1'b0;
      reset               <= 1'b1;
      csr_we              <= 1'b0;
      csr_wdata           <= '0;
      req_chan.valid      <= 1'b0;
      req_chan.func       <= FUNC_RECORD;
      req_chan.acceptance <= '0;
      req_chan.entropy    <= '0;
      req_chan.steps      <= '0;
      req_chan.confidence <= '0;
      repeat (RESET_LEN) @(posedge clock);
      reset <= 1'b0;

      test_empty_store();
      test_record_clamping();
      test_query_limits();
      test_default_register();
      test_random_traffic(RANDOM_ITEMS);

      // Wait out stragglers so any extra result is caught.
      drain_verdicts();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_verdicts.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
